[design/bba_pkg.sv]
// Shared types and codes for the bitmap block allocator.
// Used by bba_ctrl, bba_dp and bitmap_block_allocator_core; depends on nothing.
package bba_pkg;

	// Command codes on the input channel
	localparam logic [1:0] CMD_ALLOC     = 2'd0;
	localparam logic [1:0] CMD_FREE_RUN  = 2'd1;
	localparam logic [1:0] CMD_MARK_USED = 2'd2;
	localparam logic [1:0] CMD_MARK_FREE = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_ZERO_CNT = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load;        // capture a new command
		logic clr_wr;      // clearing pass: write all ones, advance word
		logic scan_start;  // restart the first-fit search at word 0
		logic rd;          // read the current word
		logic scan_eval;   // word-level search step on read data
		logic bit_step;    // bit-level search step
		logic rmw_start;   // word pointer to the run start's word, or word 0
		logic rmw_skip;    // advance word without touching memory
		logic rmw_wr;      // write back the masked word, advance
		logic post_start;  // set up the block 0 re-mark
		logic cnt_upd;     // update the used count
		logic set_fail;    // result: no space
		logic set_zero;    // result: zero count
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic is_alloc;
		logic is_mark_free;
		logic post_done;
		logic zero_cnt;
		logic short_free;
		logic scan_end;
		logic ev_found;
		logic ev_mixed;
		logic bit_end;
		logic bit_found;
		logic bit_last;
		logic rmw_done;
		logic rmw_before;
	} dp_stat_t;

endpackage

[design/bba_ctrl.sv]
// Sequencing state machine of the bitmap block allocator.
// Depends on bba_pkg for the command and status structs.
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_free,
	output logic              out_load,
	input  bba_pkg::dp_stat_t st,
	output bba_pkg::dp_cmd_t  cmd
);

	localparam logic [3:0] S_CLR      = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_DISP     = 4'd2;
	localparam logic [3:0] S_SCAN_RD  = 4'd3;
	localparam logic [3:0] S_SCAN_EV  = 4'd4;
	localparam logic [3:0] S_SCAN_BIT = 4'd5;
	localparam logic [3:0] S_RMW_INIT = 4'd6;
	localparam logic [3:0] S_RMW_RD   = 4'd7;
	localparam logic [3:0] S_RMW_WR   = 4'd8;
	localparam logic [3:0] S_POST     = 4'd9;
	localparam logic [3:0] S_FIN      = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		out_load = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (st.is_alloc) begin
					if (st.zero_cnt) begin
						cmd.set_zero = 1'b1;
						state_d      = S_FIN;
					end else if (st.short_free) begin
						cmd.set_fail = 1'b1;
						state_d      = S_FIN;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN_RD;
					end
				end else if (st.zero_cnt) begin
					state_d = S_POST;
				end else begin
					state_d = S_RMW_INIT;
				end
			end
			S_SCAN_RD: begin
				if (st.scan_end) begin
					cmd.set_fail = 1'b1;
					state_d      = S_FIN;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				cmd.scan_eval = 1'b1;
				if (st.ev_found) begin
					state_d = S_RMW_INIT;
				end else if (st.ev_mixed) begin
					state_d = S_SCAN_BIT;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_BIT: begin
				if (st.bit_end) begin
					cmd.set_fail = 1'b1;
					state_d      = S_FIN;
				end else begin
					cmd.bit_step = 1'b1;
					if (st.bit_found) begin
						state_d = S_RMW_INIT;
					end else if (st.bit_last) begin
						state_d = S_SCAN_RD;
					end
				end
			end
			S_RMW_INIT: begin
				cmd.rmw_start = 1'b1;
				state_d       = S_RMW_RD;
			end
			S_RMW_RD: begin
				if (st.rmw_done) begin
					state_d = S_POST;
				end else if (st.rmw_before) begin
					cmd.rmw_skip = 1'b1;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_RMW_WR;
				end
			end
			S_RMW_WR: begin
				cmd.rmw_wr = 1'b1;
				state_d    = S_RMW_RD;
			end
			S_POST: begin
				if (st.is_mark_free && !st.post_done) begin
					cmd.post_start = 1'b1;
					state_d        = S_RMW_INIT;
				end else begin
					cmd.cnt_upd = 1'b1;
					state_d     = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state; start with the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/bba_dp.sv]
// Datapath of the bitmap block allocator: used map memory, search and run
// registers, used count and total register. Depends on bba_pkg.
module bba_dp #(
	parameter int MAP_WORDS = 1024,
	parameter int WORD_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bba_pkg::dp_cmd_t  cmd,
	output bba_pkg::dp_stat_t st,
	input  logic [1:0]        in_cmd,
	input  logic [14:0]       in_start,
	input  logic [15:0]       in_count,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	output logic [1:0]        res_status,
	output logic [14:0]       res_granted,
	output logic [15:0]       res_used
);

	localparam int PW   = 18;
	localparam int AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int OW   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam bit POW2 = ((1 << OW) == WORD_BITS);
	localparam int CAP  = MAP_WORDS * WORD_BITS;
	localparam int CAPL = (CAP > 65535) ? 65535 : CAP;
	localparam logic [PW-1:0] WB_P   = PW'(WORD_BITS);
	localparam logic [PW-1:0] MW_P   = PW'(MAP_WORDS);
	localparam logic [PW-1:0] MWL_P  = PW'(MAP_WORDS - 1);
	localparam logic [15:0]   CAPL16 = 16'(CAPL);
	localparam logic [OW-1:0] BLAST  = OW'(WORD_BITS - 1);

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rd_q;
	logic [WORD_BITS-1:0] data_q;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] wr_data;

	logic [1:0]    cmd_q;
	logic [PW-1:0] lo_q, hi_q, run_q, base_q, word_q, granted_q;
	logic [15:0]   cnt_q, used_q, total_q;
	logic [OW-1:0] bit_q;
	logic [1:0]    status_q;
	logic          val_q, post_q;

	logic [15:0]   lim;
	logic [PW-1:0] lim_p, cnt_p, base_end, run_wb, run_inc, pos;
	logic [PW-1:0] g_fast, g_bit;
	logic          fits, wfree, wfull;
	logic [16:0]   sum_up;
	logic [15:0]   used_up, used_dn;
	logic [AW-1:0] widx;

	assign widx = word_q[AW-1:0];

	// Effective total and search helpers
	assign lim      = (total_q < CAPL16) ? total_q : CAPL16;
	assign lim_p    = {2'b00, lim};
	assign cnt_p    = {2'b00, cnt_q};
	assign base_end = base_q + WB_P;
	assign run_wb   = run_q + WB_P;
	assign run_inc  = run_q + PW'(1);
	assign pos      = base_q + PW'(bit_q);
	assign fits     = (base_end <= lim_p);
	assign wfree    = (rd_q == '0);
	assign wfull    = &rd_q;
	assign g_fast   = base_q - run_q;
	assign g_bit    = pos + PW'(1) - cnt_p;

	// Bits of the current word that fall inside [lo, hi)
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			mask[i] = ((base_q + PW'(i)) >= lo_q) && ((base_q + PW'(i)) < hi_q);
		end
		wr_data = val_q ? (rd_q | mask) : (rd_q & ~mask);
	end

	// Saturating count updates
	assign sum_up  = {1'b0, used_q} + {1'b0, cnt_q};
	assign used_up = (sum_up > {1'b0, lim}) ? lim : sum_up[15:0];
	assign used_dn = (used_q > cnt_q) ? (used_q - cnt_q) : 16'd0;

	// Status to the controller
	always_comb begin
		st              = '0;
		st.clr_last     = (word_q == MWL_P);
		st.is_alloc     = (cmd_q == bba_pkg::CMD_ALLOC);
		st.is_mark_free = (cmd_q == bba_pkg::CMD_MARK_FREE);
		st.post_done    = post_q;
		st.zero_cnt     = (cnt_q == 16'd0);
		st.short_free   = (used_q >= lim) || ((lim - used_q) < cnt_q);
		st.scan_end     = (base_q >= lim_p);
		st.ev_found     = wfree && fits && (run_wb >= cnt_p);
		st.ev_mixed     = !(fits && (wfree || wfull));
		st.bit_end      = (pos >= lim_p);
		st.bit_found    = !data_q[bit_q] && (run_inc == cnt_p);
		st.bit_last     = (bit_q == BLAST);
		st.rmw_done     = (base_q >= hi_q) || (word_q >= MW_P);
		st.rmw_before   = (base_end <= lo_q);
	end

	// Used map memory: registered read, one write port
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem[widx];
		end
		if (cmd.clr_wr) begin
			mem[widx] <= '1;
		end else if (cmd.rmw_wr) begin
			mem[widx] <= wr_data;
		end
	end

	// Word pointer and search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			base_q <= '0;
		end else if (cmd.clr_wr) begin
			word_q <= word_q + PW'(1);
		end else if (cmd.scan_start) begin
			word_q <= '0;
			base_q <= '0;
		end else if (cmd.rmw_start) begin
			if (POW2) begin
				word_q <= lo_q >> OW;
				base_q <= (lo_q >> OW) << OW;
			end else begin
				word_q <= '0;
				base_q <= '0;
			end
		end else if (cmd.rmw_skip || cmd.rmw_wr ||
				(cmd.scan_eval && !st.ev_found && !st.ev_mixed) ||
				(cmd.bit_step && !st.bit_found && st.bit_last)) begin
			word_q <= word_q + PW'(1);
			base_q <= base_end;
		end
	end

	// Command registers, run bounds and search run length
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= in_cmd;
			cnt_q     <= in_count;
			lo_q      <= {3'b000, in_start};
			hi_q      <= {3'b000, in_start} + {2'b00, in_count};
			val_q     <= (in_cmd == bba_pkg::CMD_ALLOC) || (in_cmd == bba_pkg::CMD_MARK_USED);
			post_q    <= 1'b0;
			status_q  <= bba_pkg::ST_OK;
			granted_q <= '0;
		end
		if (cmd.set_fail) begin
			status_q  <= bba_pkg::ST_NO_SPACE;
			granted_q <= '0;
		end
		if (cmd.set_zero) begin
			status_q <= bba_pkg::ST_ZERO_CNT;
		end
		if (cmd.scan_start) begin
			run_q <= '0;
		end
		if (cmd.post_start) begin
			lo_q   <= '0;
			hi_q   <= PW'(1);
			val_q  <= 1'b1;
			post_q <= 1'b1;
		end
		// Word-level step: whole free words extend the run, used words reset it
		if (cmd.scan_eval) begin
			if (st.ev_found) begin
				granted_q <= g_fast;
				lo_q      <= g_fast;
				hi_q      <= g_fast + cnt_p;
			end else if (st.ev_mixed) begin
				data_q <= rd_q;
				bit_q  <= '0;
			end else if (wfree) begin
				run_q <= run_wb;
			end else begin
				run_q <= '0;
			end
		end
		// Bit-level step through a mixed word
		if (cmd.bit_step) begin
			run_q <= data_q[bit_q] ? '0 : run_inc;
			bit_q <= bit_q + OW'(1);
			if (st.bit_found) begin
				granted_q <= g_bit;
				lo_q      <= g_bit;
				hi_q      <= g_bit + cnt_p;
			end
		end
	end

	// Used count and total register; direction follows the command, not the
	// block 0 re-mark of mark free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 16'd32768;
			total_q <= 16'd32768;
		end else begin
			if (cfg_we) begin
				total_q <= cfg_wdata;
			end
			if (cmd.cnt_upd) begin
				used_q <= ((cmd_q == bba_pkg::CMD_ALLOC) ||
					(cmd_q == bba_pkg::CMD_MARK_USED)) ? used_up : used_dn;
			end
		end
	end

	assign res_status  = status_q;
	assign res_granted = granted_q[14:0];
	assign res_used    = used_q;

endmodule

[design/bitmap_block_allocator_core.sv]
// Bitmap block allocator: used map with first-fit run allocation.
// Top level; instantiates bba_ctrl and bba_dp, uses bba_pkg.
//
// Input channel s_axis: tuser carries the command (allocate, free run, mark
// used, mark free), tdata the start block and block count. Output channel
// m_axis: one result transaction per command, tuser the status, tdata the
// granted block and the used-block count after the command.
// cfg_we/cfg_wdata write total_blocks; write only while the block is idle.
// Commands run one at a time. An allocation searches the map word by word,
// reading each word and then evaluating it, taking a word whose blocks are
// all free or all used in one step and walking a mixed word one bit per
// cycle; marking a run reads and then writes back each word touched
// through the single memory port. A command with a zero count marks no run
// (mark free still rewrites block 0).
// After reset a clearing pass sets every map word to all used, one word per
// cycle, with s_axis_tready low. A result waits in the output register
// while m_axis_tready is low; the next command may be accepted meanwhile
// and completes once the register is free.
module bitmap_block_allocator_core #(
	parameter int MAP_WORDS = 1024,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // start_block[14:0], block_count[30:15], zero
	input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // granted_block[14:0], blocks_in_use[30:15], zero
	output logic [1:0]  m_axis_tuser,  // status[1:0]
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	bba_pkg::dp_cmd_t  cmd;
	bba_pkg::dp_stat_t st;
	logic              out_free, out_load;
	logic [1:0]        res_status;
	logic [14:0]       res_granted;
	logic [15:0]       res_used;
	logic [31:0]       tdata_q;
	logic [1:0]        tuser_q;
	logic              tvalid_q;

	assign out_free = !tvalid_q || m_axis_tready;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.out_load (out_load),
		.st       (st),
		.cmd      (cmd)
	);

	bba_dp #(
		.MAP_WORDS (MAP_WORDS),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.in_cmd      (s_axis_tuser),
		.in_start    (s_axis_tdata[14:0]),
		.in_count    (s_axis_tdata[30:15]),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.res_status  (res_status),
		.res_granted (res_granted),
		.res_used    (res_used)
	);

	// Output register: hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (out_load) begin
			tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			tdata_q <= {1'b0, res_used, res_granted};
			tuser_q <= res_status;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;

endmodule
